[hdl/unsigned_divider_64_top_macros.svh]
// Assertion macros shared by the verification-only checker of the divider.
// Depends on signals named clk and arst_n in the scope of use.
`ifndef UNSIGNED_DIVIDER_64_TOP_MACROS_SVH
`define UNSIGNED_DIVIDER_64_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DVD64_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DVD64_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/dvd64_pkg.sv]
// Package for the pipelined 64-bit unsigned divider.
// Holds the working width and the per-stage record; no dependencies.
`timescale 1ns / 1ps

package dvd64_pkg;

	localparam int PORT_WIDTH = 64;
	localparam int DATA_WIDTH = 64;

	typedef logic [PORT_WIDTH-1:0] port_word_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	// The nq field holds the dividend bits still to be consumed in its upper
	// part and the quotient bits produced so far in its lower part.
	typedef struct packed {
		logic  zero;
		word_t den;
		word_t rem;
		word_t nq;
	} stage_t;

endpackage

[hdl/dvd64_step.sv]
// One restoring-division step with its pipeline register.
// Depends on dvd64_pkg for the stage record.
`timescale 1ns / 1ps

module dvd64_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  dvd64_pkg::stage_t data_in,
	output logic             valid_out,
	output dvd64_pkg::stage_t data_out
);

	logic                                valid_s1;
	dvd64_pkg::stage_t                   data_s1;
	dvd64_pkg::word_t                    rem_shift;
	logic [dvd64_pkg::DATA_WIDTH:0]      diff;
	logic                                ge;
	dvd64_pkg::stage_t                   data_nxt;

	always_comb begin
		rem_shift = {data_in.rem[dvd64_pkg::DATA_WIDTH-2:0],
			data_in.nq[dvd64_pkg::DATA_WIDTH-1]};
		diff = {1'b0, rem_shift} - {1'b0, data_in.den};
		ge = !diff[dvd64_pkg::DATA_WIDTH];
		data_nxt.zero = data_in.zero;
		data_nxt.den = data_in.den;
		data_nxt.rem = ge ? diff[dvd64_pkg::DATA_WIDTH-1:0] : rem_shift;
		data_nxt.nq = {data_in.nq[dvd64_pkg::DATA_WIDTH-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= data_nxt;
		end
	end

	assign valid_out = valid_s1;
	assign data_out = data_s1;

endmodule

[hdl/dvd64_skid.sv]
// Output register with a one-beat skid stage behind it.
// Depends on dvd64_pkg for the port word type.
`timescale 1ns / 1ps

module dvd64_skid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pipe_valid,
	input  dvd64_pkg::port_word_t pipe_quo,
	output logic                  pipe_en,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dvd64_pkg::port_word_t quotient
);

	logic                  ov_q;
	logic                  sv_q;
	dvd64_pkg::port_word_t oq_q;
	dvd64_pkg::port_word_t sq_q;
	logic                  take;

	assign take = ov_q && out_ready;
	assign pipe_en = !sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (take) begin
				sv_q <= 1'b0;
			end
		end else if (pipe_valid) begin
			if (!ov_q || take) begin
				ov_q <= 1'b1;
			end else begin
				sv_q <= 1'b1;
			end
		end else if (take) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (take) begin
				oq_q <= sq_q;
			end
		end else if (pipe_valid) begin
			if (!ov_q || take) begin
				oq_q <= pipe_quo;
			end else begin
				sq_q <= pipe_quo;
			end
		end
	end

	assign out_valid = ov_q;
	assign quotient = oq_q;

endmodule

[hdl/unsigned_divider_64_top.sv]
// Pipelined 64-bit unsigned restoring divider, top level.
// Depends on dvd64_pkg, dvd64_step and dvd64_skid.
//
// Usage: present dividend and divisor with in_valid; a beat is taken when
// in_valid and in_ready are both high. The quotient comes out on quotient
// with out_valid and is taken when out_valid and out_ready are both high.
// A zero divisor gives a quotient of zero.
// The divider is a chain of 64 register stages, one quotient bit each, each
// stage holding one 64-bit subtract and compare. A beat taken at one edge
// is loaded into the first of the 64 step stages, moves through the rest of
// them in order, and the output register takes its result from the last.
// Throughput is one beat per cycle for as long as the receiver keeps up.
// When the receiver stalls, the output register holds its beat and the next
// result lands in a skid stage; once that is full the whole pipeline halts
// and in_ready drops, so nothing is lost or repeated. in_ready is driven from
// a register and has no combinational path from out_ready.
// Reset clears all valid bits; the pipeline is empty and in_ready is high
// right after reset.
`timescale 1ns / 1ps

module unsigned_divider_64_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dvd64_pkg::port_word_t dividend,
	input  dvd64_pkg::port_word_t divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output dvd64_pkg::port_word_t quotient
);

	localparam int Steps = dvd64_pkg::DATA_WIDTH;

	logic              pipe_en;
	logic              valid_c [Steps+1];
	dvd64_pkg::stage_t data_c  [Steps+1];
	dvd64_pkg::port_word_t pipe_quo;

	always_comb begin
		valid_c[0] = in_valid;
		data_c[0].den = divisor[dvd64_pkg::DATA_WIDTH-1:0];
		data_c[0].zero = (divisor[dvd64_pkg::DATA_WIDTH-1:0] == '0);
		data_c[0].rem = '0;
		data_c[0].nq = dividend[dvd64_pkg::DATA_WIDTH-1:0];
	end

	for (genvar k = 0; k < Steps; k++) begin : g_step
		dvd64_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.valid_in  (valid_c[k]),
			.data_in   (data_c[k]),
			.valid_out (valid_c[k+1]),
			.data_out  (data_c[k+1])
		);
	end

	assign pipe_quo = data_c[Steps].zero ? '0 :
		dvd64_pkg::PORT_WIDTH'(data_c[Steps].nq);

	dvd64_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (valid_c[Steps]),
		.pipe_quo   (pipe_quo),
		.pipe_en    (pipe_en),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.quotient   (quotient)
	);

	assign in_ready = pipe_en;

endmodule

[hdl/dvd64_chk.sv]
// Port-level checker for the divider, bound to the top level.
// Depends on unsigned_divider_64_top_macros.svh and dvd64_pkg.
`timescale 1ns / 1ps
`include "unsigned_divider_64_top_macros.svh"

module dvd64_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input dvd64_pkg::port_word_t quotient
);

	`DVD64_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
		"output beat dropped while stalled")
	`DVD64_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(quotient),
		"stalled quotient changed")
	`DVD64_ASSERT_NOW(a_busy_needs_out, !in_ready, out_valid,
		"input blocked with no result waiting")
	`DVD64_ASSERT_NOW(a_ready_drop, $fell(in_ready),
		$past(out_valid) && !$past(out_ready),
		"input blocked without an output stall")

endmodule

bind unsigned_divider_64_top dvd64_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quotient  (quotient)
);

[tb/sv/tb_unsigned_divider_64_top.sv]
// Self-checking testbench for unsigned_divider_64_top: random and directed divisions
// checked against a bit-serial restoring-division predictor, with random idling on both sides.
// Depends on dvd64_pkg and unsigned_divider_64_top.
`timescale 1ns / 1ps

module tb_unsigned_divider_64_top;

	localparam int RANDOM_ITEMS = 1050;
	localparam int TAIL_ITEMS = 150;
	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS = 50;

	typedef struct {
		dvd64_pkg::port_word_t num;
		dvd64_pkg::port_word_t den;
		bit                    wait_empty;
	} division_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	dvd64_pkg::port_word_t dividend = '0;
	dvd64_pkg::port_word_t divisor = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	dvd64_pkg::port_word_t quotient;

	division_t             division_q[$];
	dvd64_pkg::port_word_t quotient_q[$];
	int                    in_flight = 0;
	int unsigned           error_cnt = 0;
	int unsigned           send_gap = 0;
	int unsigned           stall_left = 0;
	int unsigned           quiet_cnt = 0;
	logic                  tail_phase = 1'b0;

	unsigned_divider_64_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dividend (dividend),
		.divisor  (divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient (quotient)
	);

	always #5 clk = ~clk;

	function automatic dvd64_pkg::port_word_t restoring_quotient(
			dvd64_pkg::port_word_t num, dvd64_pkg::port_word_t den);
		dvd64_pkg::word_t n;
		dvd64_pkg::word_t d;
		dvd64_pkg::word_t rem;
		dvd64_pkg::word_t quo;
		n = num[dvd64_pkg::DATA_WIDTH-1:0];
		d = den[dvd64_pkg::DATA_WIDTH-1:0];
		rem = '0;
		quo = '0;
		if (d == '0) begin
			return '0;
		end
		for (int bit_idx = dvd64_pkg::DATA_WIDTH - 1; bit_idx >= 0; bit_idx--) begin
			rem = {rem[dvd64_pkg::DATA_WIDTH-2:0], n[bit_idx]};
			if (rem >= d) begin
				rem = rem - d;
				quo[bit_idx] = 1'b1;
			end
		end
		return dvd64_pkg::PORT_WIDTH'(quo);
	endfunction

	function automatic dvd64_pkg::port_word_t random_operand();
		dvd64_pkg::port_word_t w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return w;
			1: return w >> $urandom_range(1, 63);
			2: return w >> $urandom_range(48, 63);
			default: return ~(w >> $urandom_range(8, 63));
		endcase
	endfunction

	task automatic add_division(dvd64_pkg::port_word_t num, dvd64_pkg::port_word_t den,
			bit wait_empty);
		division_t d;
		d.num = num;
		d.den = den;
		d.wait_empty = wait_empty;
		division_q.push_back(d);
	endtask

	task automatic report_mismatch(string what);
		if (error_cnt < MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		error_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			dividend <= '0;
			divisor <= '0;
			send_gap <= 0;
			tail_phase <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (division_q.size() != 0 &&
					(!division_q[0].wait_empty || (in_flight == 0 && !in_valid))) begin
				dividend <= division_q[0].num;
				divisor <= division_q[0].den;
				in_valid <= 1'b1;
				tail_phase <= (division_q.size() <= TAIL_ITEMS);
				if (division_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(1, 7);
				end
				void'(division_q.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight <= 0;
			quiet_cnt <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (quotient_q.size() == 0) begin
					report_mismatch($sformatf("unexpected quotient %h", quotient));
				end else begin
					if (quotient !== quotient_q[0]) begin
						report_mismatch($sformatf("quotient %h, expected %h",
							quotient, quotient_q[0]));
					end
					void'(quotient_q.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				quotient_q.push_back(restoring_quotient(dividend, divisor));
			end
			in_flight <= in_flight + int'(in_valid && in_ready) - int'(out_valid && out_ready);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cnt <= 0;
			end else if (quiet_cnt + 1 >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("FAIL unsigned_divider_64_top");
				$finish;
			end else begin
				quiet_cnt <= quiet_cnt + 1;
			end
		end
	end

	initial begin
		dvd64_pkg::port_word_t num;
		dvd64_pkg::port_word_t den;
		dvd64_pkg::port_word_t all_ones;
		dvd64_pkg::port_word_t msb;
		all_ones = '1;
		msb = dvd64_pkg::port_word_t'(1) << 63;

		add_division('0, '0, 1'b0);
		add_division(64'd1, '0, 1'b0);
		add_division(all_ones, '0, 1'b0);
		add_division('0, 64'd1, 1'b0);
		add_division('0, all_ones, 1'b0);
		add_division(all_ones, 64'd1, 1'b0);
		add_division(all_ones, all_ones, 1'b0);
		add_division(all_ones, 64'd2, 1'b0);
		add_division(all_ones, all_ones - 1, 1'b0);
		add_division(all_ones - 1, all_ones, 1'b0);
		add_division(64'd1, 64'd1, 1'b0);
		add_division(64'd1, 64'd2, 1'b0);
		add_division(msb, 64'd1, 1'b0);
		add_division(msb, msb, 1'b0);
		add_division(all_ones, msb, 1'b0);
		add_division(msb - 1, msb, 1'b0);
		add_division(msb, 64'd3, 1'b0);
		add_division(64'd100, 64'd7, 1'b0);
		add_division(64'd7, 64'd100, 1'b0);
		add_division(all_ones, 64'd3, 1'b0);
		add_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
		add_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		add_division(64'h1234_5678_9ABC_DEF0, 64'h10, 1'b0);
		add_division(all_ones, 64'hFFFF_FFFF, 1'b0);
		add_division(64'h1_0000_0000, 64'h1_0000_0001, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			den = random_operand();
			case ($urandom_range(0, 9))
				0: begin
					den = '0;
					num = random_operand();
				end
				1: num = den;
				2: num = den - 1;
				3: num = den * $urandom_range(1, 1000) + $urandom_range(0, 999);
				default: num = random_operand();
			endcase
			add_division(num, den, i == 0 || i == RANDOM_ITEMS / 2);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (division_q.size() != 0 || in_valid) @(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (quotient_q.size() != 0) begin
			report_mismatch($sformatf("%0d quotients never arrived", quotient_q.size()));
		end
		if (error_cnt == 0) begin
			$display("PASS unsigned_divider_64_top");
		end else begin
			$display("FAIL unsigned_divider_64_top");
		end
		$finish;
	end

endmodule
